@@ src/cspsg_pkg.sv @@
// Shared constants and types of the cos-squared pulse sample generator.
package cspsg_pkg;

   localparam int CSR_WIDTH = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [CSR_WIDTH-1:0] csr_word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register map of the configuration port.
   localparam csr_index_type CSR_CARRIER_STEP  = 2'd0;
   localparam csr_index_type CSR_ENVELOPE_STEP = 2'd1;
   localparam csr_index_type CSR_AMPLITUDE     = 2'd2;
   localparam csr_index_type CSR_PULSE_POINTS  = 2'd3;

   localparam csr_word_type PULSE_POINTS_RESET = 16'd2;

   // Q15 odd polynomial for sine on a quarter turn: z*(A - z2*(B - z2*C)).
   localparam logic [15:0] POLY_A = 16'd51472;
   localparam logic [15:0] POLY_B = 16'd21024;
   localparam logic [15:0] POLY_C = 16'd2320;

   localparam logic [15:0] Q15_ONE = 16'd32768;

   // Rounding bias for the final scale by 2^-30.
   localparam logic [51:0] ROUND_BIAS = 52'd536870912;

endpackage

@@ src/cos_squared_pulse_sample_generator.sv @@
// Top level of the cos-squared pulse sample generator: an eight-stage sample pipeline.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   req      | in        | req_valid/req_stall  | req_sample_index
//   rsp      | out       | rsp_valid/rsp_stall  | rsp_sample_value, rsp_inside_pulse
//   csr      | in        | csr_write_enable     | csr_index, csr_write_data
//
// One transaction enters per cycle while req_stall is low.
// The depth is set by the chain of Q15 multiplies of the sine polynomial, the envelope
// product and the amplitude product, with at most one multiply per lane in each stage.
// Reset zeroes the steps and amplitude, presets pulse_points_ff and clears vld_ff.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles are
// squeezed out and a stall on rsp backs up into req only once all stages are full.
module cos_squared_pulse_sample_generator
   import cspsg_pkg::*;
#(
   parameter int PHASE_BITS  = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int INDEX_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [INDEX_BITS-1:0]         req_sample_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_value,
   output logic                          rsp_inside_pulse,
   input  logic                          csr_write_enable,
   input  csr_index_type                 csr_index,
   input  csr_word_type                  csr_write_data
);

   localparam int STAGES = 8;
   localparam int MW     = PHASE_BITS + CSR_WIDTH;
   localparam int CMPW   = (INDEX_BITS > CSR_WIDTH) ? INDEX_BITS : CSR_WIDTH;
   localparam int RW     = 22;
   localparam int CW     = ((SAMPLE_BITS > RW) ? SAMPLE_BITS : RW) + 1;
   localparam logic signed [CW-1:0] SAT_HI =
      CW'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
   localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

   // Configuration registers.
   csr_word_type               carrier_step_ff;
   csr_word_type               envelope_step_ff;
   logic signed [CSR_WIDTH-1:0] amplitude_ff;
   csr_word_type               pulse_points_ff;

   // Pipeline control.
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] vld_in;
   logic [STAGES:1] stage_rdy;
   logic [STAGES:1] inside_ff;

   // Lane 0 carries the carrier phase, lane 1 the doubled envelope phase.
   logic [PHASE_BITS-1:0] ph_ff [2];
   logic [PHASE_BITS-1:0] ph_in [2];
   logic [15:0]           z2s_ff [2];
   logic [15:0]           z2s_in [2];
   logic [15:0]           zsq2_ff [2];
   logic [15:0]           zsq2_in [2];
   logic                  neg2_ff [2];
   logic                  neg2_in [2];
   logic [15:0]           z3s_ff [2];
   logic [15:0]           zsq3_ff [2];
   logic [15:0]           t1_ff [2];
   logic [15:0]           t1_in [2];
   logic                  neg3_ff [2];
   logic [15:0]           z4s_ff [2];
   logic [15:0]           t2_ff [2];
   logic [15:0]           t2_in [2];
   logic                  neg4_ff [2];
   logic signed [17:0]    cos_ff [2];
   logic signed [17:0]    cos_in [2];
   logic signed [35:0]    prod_ff;
   logic signed [35:0]    prod_in;
   logic signed [51:0]    scaled_ff;
   logic signed [51:0]    scaled_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                  inside_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff  <= '0;
         envelope_step_ff <= '0;
         amplitude_ff     <= '0;
         pulse_points_ff  <= PULSE_POINTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CARRIER_STEP:  carrier_step_ff  <= csr_write_data;
            CSR_ENVELOPE_STEP: envelope_step_ff <= csr_write_data;
            CSR_AMPLITUDE:     amplitude_ff     <= $signed(csr_write_data);
            CSR_PULSE_POINTS:  pulse_points_ff  <= csr_write_data;
         endcase
      end
   end

   // A stage may load when it is empty or its content moves on in the same cycle.
   always_comb begin
      stage_rdy[STAGES] = !vld_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_rdy[k] = !vld_ff[k] || stage_rdy[k+1];
      end
      vld_in[1] = stage_rdy[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = stage_rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: phases modulo 2^PHASE_BITS and the pulse window compare.
   always_comb begin
      logic [PHASE_BITS-1:0] idx_ph;
      logic [MW-1:0]         prod_c;
      logic [MW-1:0]         prod_e;
      idx_ph    = PHASE_BITS'(req_sample_index);
      prod_c    = MW'(idx_ph) * MW'(carrier_step_ff);
      prod_e    = MW'(idx_ph) * MW'(envelope_step_ff);
      ph_in[0]  = prod_c[PHASE_BITS-1:0];
      ph_in[1]  = prod_e[PHASE_BITS-1:0];
      inside_in = CMPW'(req_sample_index) < CMPW'(pulse_points_ff);
   end

   // Stage 2: turn fraction, quarter-turn shift for cosine, quadrant fold, z squared.
   always_comb begin
      logic [31:0] u;
      logic [1:0]  quad;
      logic [15:0] zf;
      logic [31:0] sq;
      for (int l = 0; l < 2; l++) begin
         if (l == 0) begin
            u = 32'(ph_ff[l]) << (32 - PHASE_BITS);
         end else begin
            u = 32'(ph_ff[l]) << (33 - PHASE_BITS);
         end
         quad = u[31:30] + 2'd1;
         zf   = quad[0] ? (Q15_ONE - {1'b0, u[29:15]}) : {1'b0, u[29:15]};
         sq   = 32'(zf) * 32'(zf);
         z2s_in[l]  = zf;
         zsq2_in[l] = sq[30:15];
         neg2_in[l] = quad[1];
      end
   end

   // Stage 3: inner polynomial term.
   always_comb begin
      logic [31:0] pc;
      for (int l = 0; l < 2; l++) begin
         pc       = 32'(zsq2_ff[l]) * 32'(POLY_C);
         t1_in[l] = POLY_B - pc[30:15];
      end
   end

   // Stage 4: outer polynomial term.
   always_comb begin
      logic [31:0] pt;
      for (int l = 0; l < 2; l++) begin
         pt       = 32'(zsq3_ff[l]) * 32'(t1_ff[l]);
         t2_in[l] = POLY_A - pt[30:15];
      end
   end

   // Stage 5: final multiply by z and the sign of the lower half turn.
   always_comb begin
      logic [31:0]        ps;
      logic signed [17:0] mag;
      for (int l = 0; l < 2; l++) begin
         ps        = 32'(z4s_ff[l]) * 32'(t2_ff[l]);
         mag       = $signed({1'b0, ps[31:15]});
         cos_in[l] = neg4_ff[l] ? -mag : mag;
      end
   end

   // Stage 6: envelope sin^2 = (1 - cos 2x) / 2, then carrier times envelope.
   always_comb begin
      logic signed [18:0] env_full;
      logic signed [17:0] env;
      env_full = 19'sd32768 - 19'(cos_ff[1]);
      env      = $signed({1'b0, env_full[17:1]});
      prod_in  = cos_ff[0] * env;
   end

   // Stage 7: amplitude.
   assign scaled_in = prod_ff * amplitude_ff;

   // Stage 8: round half up by 2^-30, saturate, force zero outside the pulse.
   always_comb begin
      logic signed [51:0] biased;
      logic signed [CW-1:0] rounded;
      biased  = scaled_ff + $signed(ROUND_BIAS);
      rounded = CW'($signed(biased[51:30]));
      priority if (!inside_ff[STAGES-1]) begin
         sample_in = '0;
      end else if (rounded > SAT_HI) begin
         sample_in = SAMPLE_BITS'(SAT_HI);
      end else if (rounded < SAT_LO) begin
         sample_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         sample_in = SAMPLE_BITS'(rounded);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         ph_ff        <= ph_in;
         inside_ff[1] <= inside_in;
      end
      if (stage_rdy[2]) begin
         z2s_ff       <= z2s_in;
         zsq2_ff      <= zsq2_in;
         neg2_ff      <= neg2_in;
         inside_ff[2] <= inside_ff[1];
      end
      if (stage_rdy[3]) begin
         z3s_ff       <= z2s_ff;
         zsq3_ff      <= zsq2_ff;
         t1_ff        <= t1_in;
         neg3_ff      <= neg2_ff;
         inside_ff[3] <= inside_ff[2];
      end
      if (stage_rdy[4]) begin
         z4s_ff       <= z3s_ff;
         t2_ff        <= t2_in;
         neg4_ff      <= neg3_ff;
         inside_ff[4] <= inside_ff[3];
      end
      if (stage_rdy[5]) begin
         cos_ff       <= cos_in;
         inside_ff[5] <= inside_ff[4];
      end
      if (stage_rdy[6]) begin
         prod_ff      <= prod_in;
         inside_ff[6] <= inside_ff[5];
      end
      if (stage_rdy[7]) begin
         scaled_ff    <= scaled_in;
         inside_ff[7] <= inside_ff[6];
      end
      if (stage_rdy[8]) begin
         sample_ff    <= sample_in;
         inside_ff[8] <= inside_ff[7];
      end
   end

   assign req_stall        = !stage_rdy[1];
   assign rsp_valid        = vld_ff[STAGES];
   assign rsp_sample_value = sample_ff;
   assign rsp_inside_pulse = inside_ff[STAGES];

   // With nothing waiting at the output every stage can move, so input is never held.
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the output stage is empty");

   // A sample outside the pulse window is always zero.
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_pulse) |-> (rsp_sample_value == '0))
      else $error("nonzero sample outside the pulse");

   // Reset empties the whole pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // A stalled output transaction is held and the stage before it cannot overrun it.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && vld_ff[STAGES-1]) |=> (rsp_valid && vld_ff[STAGES-1]))
      else $error("pipeline content lost under stall");

endmodule
